// ===== rtl/core/key_value_line_unescaper_defines.svh =====
// ----------------------------------------------------------------------------
// key_value_line_unescaper_defines.svh
// Assertion macros shared by the checker of the line unescaper.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_LINE_UNESCAPER_DEFINES_SVH
`define KEY_VALUE_LINE_UNESCAPER_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define KVLU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Implication checked on every clock outside reset.
`define KVLU_IMPLY(label, cond, expr, msg) \
    `KVLU_ASSERT(label, (cond) |-> (expr), msg)

// Implication checked in the cycle after the condition.
`define KVLU_NEXT(label, cond, expr, msg) \
    `KVLU_ASSERT(label, (cond) |=> (expr), msg)

`endif

// ===== rtl/core/kvlu_pkg.sv =====
// ----------------------------------------------------------------------------
// kvlu_pkg
// Types and character constants of the key/value line unescaper.
// ----------------------------------------------------------------------------
package kvlu_pkg;

    localparam int BYTE_W = 8;
    localparam int CR_W   = 6;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CR_W-1:0]   cr_count_t;

    // Input item kind
    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Character codes
    localparam byte_t CH_LF    = 8'h0A;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_SLASH = 8'h2F;
    localparam byte_t CH_COLON = 8'h3A;
    localparam byte_t CH_BSL   = 8'h5C;
    localparam byte_t CH_N     = 8'h6E;

    typedef enum logic [1:0] {
        KIND_KEY    = 2'd0,
        KIND_VALUE  = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_SLASH = 3'd1,
        PH_KEY   = 3'd2,
        PH_VALUE = 3'd3,
        PH_ESC   = 3'd4,
        PH_SKIP  = 3'd5
    } phase_t;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_BUSY = 1'b1
    } seq_state_t;

endpackage

// ===== rtl/core/key_value_line_unescaper.sv =====
// ----------------------------------------------------------------------------
// key_value_line_unescaper
// Splits a byte stream into key/value lines and unescapes the values.
// ----------------------------------------------------------------------------
// Usage:
//   Input transfers carry one text byte (s_tdata) or an end-of-text mark
//   (s_tuser = 1). Output transfers carry key bytes, value bytes, an entry
//   complete mark or a reject mark (m_tuser); m_tlast flags the last result
//   caused by one input transfer. An input may cause no result at all.
//   The first result of an input is registered in the result plan, then
//   loaded into the output register. An input with R results keeps the
//   block busy until its last result is loaded (an input with no results
//   leaves it idle); held carriage returns flushed by a later byte make R
//   up to 64. When the receiver keeps up, one result leaves per cycle
//   through a single down-counter and the output register. s_tready stays
//   low while results of an input are still being produced; the next input
//   can be taken while the last result still waits in the output register.
//   When the receiver stalls, the output register holds its transfer and
//   the sequencer waits. Reset returns to line start with no held CRs and
//   an empty output register.
// ----------------------------------------------------------------------------
module key_value_line_unescaper #(
    parameter int PENDING_CR_MAX = 63
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  kvlu_pkg::byte_t      s_tdata,   // [7:0] data_byte
    input  logic                 s_tuser,   // [0] action
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output kvlu_pkg::byte_t      m_tdata,   // [7:0] out_byte
    output logic [1:0]           m_tuser,   // [1:0] out_kind
    output logic                 m_tlast    // burst_last
);
    import kvlu_pkg::*;

    localparam cr_count_t CR_MAX = CR_W'(PENDING_CR_MAX);

    // Line state
    phase_t     phase_reg, phase_next;
    cr_count_t  pend_reg, pend_next;

    // Result plan of the current input
    seq_state_t state_reg, state_next;
    logic       slash_reg, slash_next;
    cr_count_t  cr_left_reg, cr_left_next;
    kind_t      cr_kind_reg, cr_kind_next;
    logic       fin_reg, fin_next;
    kind_t      fin_kind_reg, fin_kind_next;
    byte_t      fin_byte_reg, fin_byte_next;

    // Output register
    logic       m_valid_reg, m_valid_next;
    kind_t      m_kind_reg, m_kind_next;
    byte_t      m_byte_reg, m_byte_next;
    logic       m_last_reg, m_last_next;

    // Plan decode for the incoming item
    logic       accept, is_end, eol;
    phase_t     p_phase;
    cr_count_t  p_pend, p_flush, held_one;
    logic       p_slash, p_fin;
    kind_t      p_cr_kind, p_fin_kind;
    byte_t      p_fin_byte;

    // Emit path
    logic       have_next, load, emit_last;
    cr_count_t  cr_dec;

    assign s_tready = (state_reg == SEQ_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_end   = (s_tuser == ACT_END);
    assign eol      = is_end || (s_tdata == CH_LF);
    assign held_one = (pend_reg < CR_MAX) ? pend_reg + CR_W'(1) : pend_reg;

    // Decode one input into phase update and result plan
    always_comb begin
        p_phase    = phase_reg;
        p_pend     = pend_reg;
        p_slash    = 1'b0;
        p_flush    = '0;
        p_cr_kind  = KIND_KEY;
        p_fin      = 1'b0;
        p_fin_kind = KIND_KEY;
        p_fin_byte = s_tdata;
        unique case (phase_reg)
            PH_SLASH: begin
                if (!is_end && s_tdata == CH_SLASH) begin
                    p_phase = PH_SKIP;
                end else if (eol) begin
                    p_fin      = 1'b1;
                    p_fin_kind = KIND_REJECT;
                    p_fin_byte = '0;
                    p_phase    = PH_START;
                end else begin
                    p_slash = 1'b1;
                    p_phase = PH_KEY;
                    if (s_tdata == CH_CR) begin
                        p_pend = CR_W'(1);
                    end else if (s_tdata == CH_COLON) begin
                        p_phase = PH_VALUE;
                    end else begin
                        p_fin = 1'b1;
                    end
                end
            end
            PH_KEY: begin
                if (eol) begin
                    p_pend     = '0;
                    p_fin      = 1'b1;
                    p_fin_kind = KIND_REJECT;
                    p_fin_byte = '0;
                    p_phase    = PH_START;
                end else if (s_tdata == CH_CR) begin
                    p_pend = held_one;
                end else begin
                    p_flush = pend_reg;
                    p_pend  = '0;
                    if (s_tdata == CH_COLON) begin
                        p_phase = PH_VALUE;
                    end else begin
                        p_fin = 1'b1;
                    end
                end
            end
            PH_VALUE: begin
                p_cr_kind = KIND_VALUE;
                if (eol) begin
                    p_pend     = '0;
                    p_fin      = 1'b1;
                    p_fin_kind = KIND_DONE;
                    p_fin_byte = '0;
                    p_phase    = PH_START;
                end else if (s_tdata == CH_CR) begin
                    p_pend = held_one;
                end else begin
                    p_flush = pend_reg;
                    p_pend  = '0;
                    if (s_tdata == CH_BSL) begin
                        p_phase = PH_ESC;
                    end else begin
                        p_fin      = 1'b1;
                        p_fin_kind = KIND_VALUE;
                    end
                end
            end
            PH_ESC: begin
                if (eol) begin
                    p_pend     = '0;
                    p_fin      = 1'b1;
                    p_fin_kind = KIND_DONE;
                    p_fin_byte = '0;
                    p_phase    = PH_START;
                end else if (s_tdata == CH_CR) begin
                    p_pend  = CR_W'(1);
                    p_phase = PH_VALUE;
                end else begin
                    p_fin      = 1'b1;
                    p_fin_kind = KIND_VALUE;
                    p_fin_byte = (s_tdata == CH_N) ? CH_LF : s_tdata;
                    p_phase    = PH_VALUE;
                end
            end
            PH_SKIP: begin
                if (eol) begin
                    p_phase = PH_START;
                end
            end
            default: begin
                p_pend = '0;
                if (eol || s_tdata == CH_CR) begin
                    p_phase = PH_START;
                end else if (s_tdata == CH_SLASH) begin
                    p_phase = PH_SLASH;
                end else if (s_tdata == CH_COLON) begin
                    p_phase = PH_VALUE;
                end else begin
                    p_fin   = 1'b1;
                    p_phase = PH_KEY;
                end
            end
        endcase
        // End of text closes the line and drops held CRs
        if (is_end) begin
            p_phase = PH_START;
            p_pend  = '0;
        end
    end

    // Pick the next result: slash, then held CRs, then the closing result
    assign have_next = slash_reg || (cr_left_reg != '0) || fin_reg;
    assign load      = (state_reg == SEQ_BUSY) && have_next && (!m_valid_reg || m_tready);
    assign cr_dec    = cr_left_reg - CR_W'(1);

    // Sequencer: next state, plan and output register
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        pend_next     = pend_reg;
        slash_next    = slash_reg;
        cr_left_next  = cr_left_reg;
        cr_kind_next  = cr_kind_reg;
        fin_next      = fin_reg;
        fin_kind_next = fin_kind_reg;
        fin_byte_next = fin_byte_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_byte_next   = m_byte_reg;
        m_last_next   = m_last_reg;
        emit_last     = 1'b0;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (accept) begin
                    phase_next    = p_phase;
                    pend_next     = p_pend;
                    slash_next    = p_slash;
                    cr_left_next  = p_flush;
                    cr_kind_next  = p_cr_kind;
                    fin_next      = p_fin;
                    fin_kind_next = p_fin_kind;
                    fin_byte_next = p_fin_byte;
                    if (p_slash || p_fin || p_flush != '0) begin
                        state_next = SEQ_BUSY;
                    end
                end
            end
            SEQ_BUSY: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    if (slash_reg) begin
                        m_kind_next = KIND_KEY;
                        m_byte_next = CH_SLASH;
                        emit_last   = (cr_left_reg == '0) && !fin_reg;
                        slash_next  = 1'b0;
                    end else if (cr_left_reg != '0) begin
                        m_kind_next  = cr_kind_reg;
                        m_byte_next  = CH_CR;
                        emit_last    = (cr_dec == '0) && !fin_reg;
                        cr_left_next = cr_dec;
                    end else begin
                        m_kind_next = fin_kind_reg;
                        m_byte_next = fin_byte_reg;
                        emit_last   = 1'b1;
                        fin_next    = 1'b0;
                    end
                    m_last_next = emit_last;
                    if (emit_last) begin
                        state_next = SEQ_IDLE;
                    end
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            phase_reg   <= PH_START;
            pend_reg    <= '0;
            slash_reg   <= 1'b0;
            cr_left_reg <= '0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            pend_reg    <= pend_next;
            slash_reg   <= slash_next;
            cr_left_reg <= cr_left_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cr_kind_reg  <= cr_kind_next;
        fin_kind_reg <= fin_kind_next;
        fin_byte_reg <= fin_byte_next;
        m_kind_reg   <= m_kind_next;
        m_byte_reg   <= m_byte_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/core/kvlu_checker.sv =====
// ----------------------------------------------------------------------------
// kvlu_checker
// Port-level checks of the key/value line unescaper, bound to the top level.
// ----------------------------------------------------------------------------
`include "key_value_line_unescaper_defines.svh"

module kvlu_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tready,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  kvlu_pkg::byte_t      m_tdata,   // [7:0] out_byte
    input  logic [1:0]           m_tuser,   // [1:0] out_kind
    input  logic                 m_tlast    // burst_last
);
    import kvlu_pkg::*;

    logic closing;
    logic in_burst;

    assign closing  = m_tvalid && (m_tuser == KIND_DONE || m_tuser == KIND_REJECT);
    assign in_burst = m_tvalid && !m_tlast;

    // Hold a stalled result transfer
    `KVLU_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `KVLU_NEXT(a_hold_data, m_tvalid && !m_tready,
               $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
               "result changed while stalled")
    // No new input while a burst still has results to come
    `KVLU_IMPLY(a_busy_in_burst, in_burst, !s_tready, "input taken inside a result burst")
    // Entry and reject marks close the burst and carry no byte
    `KVLU_IMPLY(a_close_mark, closing, m_tlast && m_tdata == '0, "bad closing result")

endmodule

bind key_value_line_unescaper kvlu_checker u_kvlu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
